// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file hgm_checker.
// No dependencies; take in with `include before the module header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define HGM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hgm check failed");

// Next-cycle implication, off while reset is asserted.
`define HGM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hgm check failed");

// Next-cycle implication that also holds across reset.
`define HGM_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hgm check failed");

`endif

// ===== sv/hgm_pkg.sv =====
// Shared types, constants and lookup tables of the gain map pipeline.
// No dependencies; every module file imports it.
package hgm_pkg;

    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int LOG_SEGS          = 64;
    localparam int NSTG              = 13;

    localparam logic [15:0] ONE_Q15   = 16'd32768;
    localparam logic [15:0] GAMMA_ONE = 16'd4096;
    localparam logic signed [24:0] OUT_MAX = 25'sh0FFFFFF;
    localparam logic signed [24:0] OUT_MIN = 25'sh1000000;

    typedef enum logic [2:0] {
        CFG_LMIN   = 3'd0,
        CFG_LMAX   = 3'd1,
        CFG_GAMMA  = 3'd2,
        CFG_SDROFF = 3'd3,
        CFG_HDROFF = 3'd4,
        CFG_WEIGHT = 3'd5,
        CFG_MODE   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] lmin;
        logic signed [15:0] lmax;
        logic [15:0]        inv_gamma;
        logic signed [15:0] sdr_off;
        logic signed [15:0] hdr_off;
    } lane_cfg_t;

    typedef struct packed {
        logic [NSTG-1:0] en;
    } pipe_ctl_t;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] delta;
        logic [15:0] rem;
    } exp_seg_t;

    typedef struct packed {
        logic [16:0] base;
        logic [16:0] delta;
        logic [8:0]  rem;
        logic [3:0]  sh;
    } log_seg_t;

    typedef logic [31:0] exp_tab_t [0:EXP_TABLE_ENTRIES];
    typedef logic [16:0] log_tab_t [0:LOG_SEGS];

    // r^N under truncating Q1.30 multiplies, stopping once past 2.0
    function automatic logic [63:0] pow_root(input logic [63:0] r);
        logic [63:0] p;
        logic        done;
        p    = 64'd1 << 30;
        done = 1'b0;
        for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
            if (!done) begin
                p = (p * r) >> 30;
                if (p > (64'd1 << 31)) done = 1'b1;
            end
        end
        return p;
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] acc;
        lo = 64'd1 << 30;
        hi = 64'd1 << 31;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (pow_root(mid) <= (64'd1 << 31)) lo = mid;
            else hi = mid - 64'd1;
        end
        acc  = 64'd1 << 30;
        t[0] = 32'(acc);
        for (int i = 1; i < EXP_TABLE_ENTRIES; i++) begin
            acc  = (acc * lo) >> 30;
            t[i] = 32'(acc);
        end
        t[EXP_TABLE_ENTRIES] = 32'h8000_0000;
        return t;
    endfunction

    function automatic log_tab_t build_log_tab();
        log_tab_t    t;
        logic [63:0] x;
        logic [16:0] res;
        for (int i = 0; i < LOG_SEGS; i++) begin
            x   = (64'd1 << 30) + (64'(i) << 24);
            res = '0;
            for (int b = 15; b >= 0; b--) begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31)) begin
                    x = x >> 1;
                    res[b] = 1'b1;
                end
            end
            t[i] = res;
        end
        t[LOG_SEGS] = 17'd65536;
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();
    localparam log_tab_t LOG_TAB = build_log_tab();

    // Segment of 2^(u/65536): table base, slope and interpolation weight
    function automatic exp_seg_t exp_seg(input logic [15:0] u);
        exp_seg_t                   s;
        logic [15+EXP_IDX_W:0]      t;
        logic [EXP_IDX_W-1:0]       idx;
        logic [31:0]                nxt;
        t     = (16 + EXP_IDX_W)'(u) * (16 + EXP_IDX_W)'(EXP_TABLE_ENTRIES);
        idx   = t[15+EXP_IDX_W:16];
        s.rem = t[15:0];
        s.base = EXP_TAB[idx];
        nxt    = EXP_TAB[idx + EXP_IDX_W'(1)];
        s.delta = (nxt >= s.base) ? nxt - s.base : '0;
        return s;
    endfunction

    function automatic logic [31:0] exp_interp(input logic [31:0] base,
                                               input logic [31:0] delta,
                                               input logic [15:0] rem);
        logic [47:0] m;
        m = 48'(delta) * 48'(rem) + 48'd32768;
        return base + 32'(m >> 16);
    endfunction

    // Normalize g and find its log2 table segment
    function automatic log_seg_t log_seg(input logic [15:0] g);
        log_seg_t    s;
        logic [3:0]  p;
        logic [15:0] norm;
        logic [5:0]  idx;
        p = '0;
        for (int i = 0; i < 16; i++) begin
            if (g[i]) p = 4'(i);
        end
        norm   = g << (4'd15 - p);
        idx    = norm[14:9];
        s.rem  = norm[8:0];
        s.base = LOG_TAB[idx];
        s.delta = LOG_TAB[7'(idx) + 7'd1] - LOG_TAB[idx];
        s.sh   = 4'd15 - p;
        return s;
    endfunction

endpackage

// ===== sv/hgm_pipe_ctrl.sv =====
// Valid bits and stage enables of the pixel pipeline.
// Depends on hgm_pkg.
module hgm_pipe_ctrl import hgm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output pipe_ctl_t ctl
);

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] en;

    // A stage may load when it or any stage below it has a hole, or the sink takes
    always_comb begin
        for (int i = 0; i < NSTG; i++) begin
            en[i] = m_ready || ((valid_reg | NSTG'((64'd1 << i) - 64'd1)) != '1);
        end
        valid_next = valid_reg;
        for (int i = 0; i < NSTG; i++) begin
            if (en[i]) valid_next[i] = (i == 0) ? s_valid : valid_reg[(i == 0) ? 0 : i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.en  = en;
    assign s_ready = en[0];
    assign m_valid = valid_reg[NSTG-1];

endmodule

// ===== sv/hgm_gain_pow.sv =====
// Gain raised to the inverse gamma, six stages (log2, scale, exp2).
// Depends on hgm_pkg; stage enables come from hgm_pipe_ctrl.
module hgm_gain_pow import hgm_pkg::*; (
    input  logic               aclk,
    input  pipe_ctl_t          ctl,
    input  lane_cfg_t          cfg,
    input  logic [15:0]        gain_in,
    input  logic [15:0]        sdr_in,
    output logic [15:0]        gp_out,
    output logic signed [17:0] s_out
);

    // stage 0: clamp, log2 segment, offset SDR
    logic [15:0]        g_next;
    log_seg_t           ls_next;
    logic signed [17:0] s_next;
    logic               byp_next;

    always_comb begin
        g_next   = (gain_in > ONE_Q15) ? ONE_Q15 : gain_in;
        ls_next  = log_seg(g_next);
        byp_next = (cfg.inv_gamma == GAMMA_ONE) || (g_next == '0);
        s_next   = $signed({2'b00, sdr_in}) + 18'(cfg.sdr_off);
    end

    log_seg_t           ls0_reg;
    logic [15:0]        g0_reg;
    logic               byp0_reg;
    logic signed [17:0] s0_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            ls0_reg  <= ls_next;
            g0_reg   <= g_next;
            byp0_reg <= byp_next;
            s0_reg   <= s_next;
        end
    end

    // stage 1: interpolate log2, form -log2(g) in Q16
    logic [25:0] lm_next;
    logic [16:0] val_next;
    logic [19:0] mag_next;

    always_comb begin
        lm_next  = 26'(ls0_reg.delta) * 26'(ls0_reg.rem) + 26'd256;
        val_next = ls0_reg.base + 17'(lm_next >> 9);
        mag_next = {ls0_reg.sh, 16'b0} - 20'(val_next);
    end

    logic [19:0]        mag1_reg;
    logic [15:0]        g1_reg;
    logic               byp1_reg;
    logic signed [17:0] s1_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[1]) begin
            mag1_reg <= mag_next;
            g1_reg   <= g0_reg;
            byp1_reg <= byp0_reg;
            s1_reg   <= s0_reg;
        end
    end

    // stage 2: scale by inverse gamma
    logic [35:0] mp_next;

    assign mp_next = 36'(mag1_reg) * 36'(cfg.inv_gamma) + 36'd2048;

    logic [23:0]        mq2_reg;
    logic [15:0]        g2_reg;
    logic               byp2_reg;
    logic signed [17:0] s2_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            mq2_reg  <= mp_next[35:12];
            g2_reg   <= g1_reg;
            byp2_reg <= byp1_reg;
            s2_reg   <= s1_reg;
        end
    end

    // stage 3: split -mq into shift and fraction, exp2 segment
    logic [15:0] frac_next;
    logic [8:0]  shx_next;
    exp_seg_t    es_next;

    always_comb begin
        frac_next = mq2_reg[15:0];
        shx_next  = 9'd15 + 9'(mq2_reg[23:16]) + 9'(frac_next != '0);
        es_next   = exp_seg(16'd0 - frac_next);
    end

    exp_seg_t           es3_reg;
    logic [5:0]         sh3_reg;
    logic               zero3_reg;
    logic [15:0]        g3_reg;
    logic               byp3_reg;
    logic signed [17:0] s3_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[3]) begin
            es3_reg   <= es_next;
            sh3_reg   <= shx_next[5:0];
            zero3_reg <= (shx_next > 9'd40);
            g3_reg    <= g2_reg;
            byp3_reg  <= byp2_reg;
            s3_reg    <= s2_reg;
        end
    end

    // stage 4: interpolate exp2
    logic [31:0]        e24_reg;
    logic [5:0]         sh4_reg;
    logic               zero4_reg;
    logic [15:0]        g4_reg;
    logic               byp4_reg;
    logic signed [17:0] s4_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[4]) begin
            e24_reg   <= exp_interp(es3_reg.base, es3_reg.delta, es3_reg.rem);
            sh4_reg   <= sh3_reg;
            zero4_reg <= zero3_reg;
            g4_reg    <= g3_reg;
            byp4_reg  <= byp3_reg;
            s4_reg    <= s3_reg;
        end
    end

    // stage 5: round to Q1.15, clamp, apply bypass
    logic [40:0] rv_next;
    logic [15:0] gp_next;

    always_comb begin
        rv_next = (41'(e24_reg) + (41'd1 << (sh4_reg - 6'd1))) >> sh4_reg;
        if (byp4_reg) begin
            gp_next = g4_reg;
        end else if (zero4_reg) begin
            gp_next = '0;
        end else if (rv_next > 41'(ONE_Q15)) begin
            gp_next = ONE_Q15;
        end else begin
            gp_next = rv_next[15:0];
        end
    end

    logic [15:0]        gp5_reg;
    logic signed [17:0] s5_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[5]) begin
            gp5_reg <= gp_next;
            s5_reg  <= s4_reg;
        end
    end

    assign gp_out = gp5_reg;
    assign s_out  = s5_reg;

endmodule

// ===== sv/hgm_boost_apply.sv =====
// Log-space boost blend, exp2 and final scale with saturation, seven stages.
// Depends on hgm_pkg; takes the gain power from hgm_gain_pow.
module hgm_boost_apply import hgm_pkg::*; (
    input  logic               aclk,
    input  pipe_ctl_t          ctl,
    input  lane_cfg_t          cfg,
    input  logic [15:0]        weight,
    input  logic [15:0]        gp_in,
    input  logic signed [17:0] s_in,
    output logic signed [24:0] hdr_out,
    output logic               clip_out
);

    // stage 6: blend = lmin*(1-gp) + lmax*gp
    logic signed [16:0] dif_next;
    logic signed [33:0] pr_next;
    logic signed [33:0] base_next;

    always_comb begin
        dif_next  = 17'(cfg.lmax) - 17'(cfg.lmin);
        pr_next   = 34'(dif_next) * 34'($signed({1'b0, gp_in}));
        base_next = $signed({{3{cfg.lmin[15]}}, cfg.lmin, 15'b0});
    end

    logic signed [31:0] blend6_reg;
    logic signed [17:0] s6_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[6]) begin
            blend6_reg <= 32'(base_next + pr_next);
            s6_reg     <= s_in;
        end
    end

    // stage 7: headroom weight
    logic signed [47:0] bw7_reg;
    logic signed [17:0] s7_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[7]) begin
            bw7_reg <= 48'(blend6_reg) * 48'($signed({1'b0, weight}));
            s7_reg  <= s6_reg;
        end
    end

    // stage 8: round to Q16, floor split, exp2 segment
    logic               neg8;
    logic [47:0]        am8;
    logic [22:0]        rq8;
    logic signed [23:0] rqs8;
    logic signed [21:0] x8;
    exp_seg_t           es_next;

    always_comb begin
        neg8    = bw7_reg[47];
        am8     = neg8 ? 48'(-bw7_reg) : 48'(bw7_reg);
        rq8     = 23'((am8 + 48'd16777216) >> 25);
        rqs8    = $signed({1'b0, rq8});
        x8      = neg8 ? 22'(-rqs8) : 22'(rqs8);
        es_next = exp_seg(x8[15:0]);
    end

    exp_seg_t           es8_reg;
    logic signed [5:0]  k8_reg;
    logic signed [17:0] s8_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[8]) begin
            es8_reg <= es_next;
            k8_reg  <= $signed(x8[21:16]);
            s8_reg  <= s7_reg;
        end
    end

    // stage 9: interpolate exp2
    logic [31:0]        e29_reg;
    logic signed [5:0]  k9_reg;
    logic signed [17:0] s9_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[9]) begin
            e29_reg <= exp_interp(es8_reg.base, es8_reg.delta, es8_reg.rem);
            k9_reg  <= k8_reg;
            s9_reg  <= s8_reg;
        end
    end

    // stage 10: scale the offset SDR value
    logic signed [50:0] prod10_reg;
    logic signed [5:0]  k10_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[10]) begin
            prod10_reg <= 51'(s9_reg) * 51'($signed({1'b0, e29_reg}));
            k10_reg    <= k9_reg;
        end
    end

    // stage 11: shift down by 30-k, round half away from zero
    logic signed [6:0]  shs11;
    logic [5:0]         sh11;
    logic               neg11;
    logic [50:0]        am11;
    logic [50:0]        rr11;
    logic signed [37:0] r_next;

    always_comb begin
        shs11  = 7'sd30 - 7'(k10_reg);
        sh11   = shs11[5:0];
        neg11  = prod10_reg[50];
        am11   = neg11 ? 51'(-prod10_reg) : 51'(prod10_reg);
        rr11   = (am11 + (51'd1 << (sh11 - 6'd1))) >> sh11;
        r_next = neg11 ? 38'(-$signed(rr11)) : 38'($signed(rr11));
    end

    logic signed [37:0] r11_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[11]) begin
            r11_reg <= r_next;
        end
    end

    // stage 12: subtract HDR offset, saturate
    logic signed [38:0] v12;
    logic signed [24:0] hdr_next;
    logic               clip_next;

    always_comb begin
        v12 = 39'(r11_reg) - 39'(cfg.hdr_off);
        if (v12 > 39'(OUT_MAX)) begin
            hdr_next  = OUT_MAX;
            clip_next = 1'b1;
        end else if (v12 < 39'(OUT_MIN)) begin
            hdr_next  = OUT_MIN;
            clip_next = 1'b1;
        end else begin
            hdr_next  = 25'(v12);
            clip_next = 1'b0;
        end
    end

    logic signed [24:0] hdr12_reg;
    logic               clip12_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[12]) begin
            hdr12_reg  <= hdr_next;
            clip12_reg <= clip_next;
        end
    end

    assign hdr_out  = hdr12_reg;
    assign clip_out = clip12_reg;

endmodule

// ===== sv/hdr_gain_map_apply.sv =====
// HDR gain-map application, top level: config registers and three channel pipes.
// Depends on hgm_pkg, hgm_pipe_ctrl, hgm_gain_pow and hgm_boost_apply.
//
// Usage: each s_ word is one SDR linear RGB pixel (Q1.15) with its normalized
// gain per channel; each m_ word is the HDR pixel in signed Q9.15 plus a flag
// that is set when any channel saturated. One result word per input word.
// Both channels use valid/ready; a word moves when both are high.
// The pipeline has 13 stages with one pixel per stage and accepts one pixel
// per cycle while m_ready is high or a stage is empty.
// Each stage loads whenever the stage below it is empty or moving, so bubbles
// close up under a stalled receiver; s_ready drops only when all stages hold
// a word and m_ready is low. Nothing is lost or repeated during a stall.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index;
// write only while the pipe is empty. Unknown indexes are ignored.
// Reset (aresetn low at a clock edge) empties the pipe and restores the
// configuration defaults: boosts 0 and 2.0, gamma bypass, offsets 1/64,
// full headroom and per-channel mode.
module hdr_gain_map_apply import hgm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_sdr_red,
    input  logic [15:0]        s_sdr_green,
    input  logic [15:0]        s_sdr_blue,
    input  logic [15:0]        s_gain_red,
    input  logic [15:0]        s_gain_green,
    input  logic [15:0]        s_gain_blue,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [24:0] m_hdr_red,
    output logic signed [24:0] m_hdr_green,
    output logic signed [24:0] m_hdr_blue,
    output logic               m_clipped
);

    logic [47:0] lmin_reg;
    logic [47:0] lmax_reg;
    logic [47:0] gamma_reg;
    logic [47:0] sdroff_reg;
    logic [47:0] hdroff_reg;
    logic [15:0] weight_reg;
    logic        mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lmin_reg   <= '0;
            lmax_reg   <= 48'h1000_1000_1000;
            gamma_reg  <= 48'h1000_1000_1000;
            sdroff_reg <= 48'h0200_0200_0200;
            hdroff_reg <= 48'h0200_0200_0200;
            weight_reg <= ONE_Q15;
            mode_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LMIN:   lmin_reg   <= cfg_wdata;
                CFG_LMAX:   lmax_reg   <= cfg_wdata;
                CFG_GAMMA:  gamma_reg  <= cfg_wdata;
                CFG_SDROFF: sdroff_reg <= cfg_wdata;
                CFG_HDROFF: hdroff_reg <= cfg_wdata;
                CFG_WEIGHT: weight_reg <= cfg_wdata[15:0];
                CFG_MODE:   mode_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    pipe_ctl_t ctl;

    hgm_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    logic [15:0] weight_c;

    assign weight_c = (weight_reg > ONE_Q15) ? ONE_Q15 : weight_reg;

    logic [15:0]        sdr_in  [3];
    logic [15:0]        gain_in [3];
    logic signed [24:0] hdr     [3];
    logic [2:0]         clip;

    always_comb begin
        sdr_in[0]  = s_sdr_red;
        sdr_in[1]  = s_sdr_green;
        sdr_in[2]  = s_sdr_blue;
        // single mode: red gain for all channels
        gain_in[0] = s_gain_red;
        gain_in[1] = mode_reg ? s_gain_green : s_gain_red;
        gain_in[2] = mode_reg ? s_gain_blue  : s_gain_red;
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [1:0]         lane;
        lane_cfg_t          lcfg;
        logic [15:0]        gp;
        logic signed [17:0] sv;

        always_comb begin
            lane           = mode_reg ? 2'(c) : 2'd0;
            lcfg.lmin      = $signed(lmin_reg[16*lane +: 16]);
            lcfg.lmax      = $signed(lmax_reg[16*lane +: 16]);
            lcfg.inv_gamma = gamma_reg[16*lane +: 16];
            lcfg.sdr_off   = $signed(sdroff_reg[16*lane +: 16]);
            lcfg.hdr_off   = $signed(hdroff_reg[16*lane +: 16]);
        end

        hgm_gain_pow u_pow (
            .aclk    (aclk),
            .ctl     (ctl),
            .cfg     (lcfg),
            .gain_in (gain_in[c]),
            .sdr_in  (sdr_in[c]),
            .gp_out  (gp),
            .s_out   (sv)
        );

        hgm_boost_apply u_boost (
            .aclk     (aclk),
            .ctl      (ctl),
            .cfg      (lcfg),
            .weight   (weight_c),
            .gp_in    (gp),
            .s_in     (sv),
            .hdr_out  (hdr[c]),
            .clip_out (clip[c])
        );
    end

    assign m_hdr_red   = hdr[0];
    assign m_hdr_green = hdr[1];
    assign m_hdr_blue  = hdr[2];
    assign m_clipped   = |clip;

endmodule

// ===== sv/hgm_checker.sv =====
// Port-level checks of the gain map pipeline, bound to the top level.
// Depends on hgm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hgm_checker import hgm_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_we,
    input logic [2:0]         cfg_index,
    input logic [47:0]        cfg_wdata,
    input logic               s_valid,
    input logic               s_ready,
    input logic [15:0]        s_sdr_red,
    input logic [15:0]        s_sdr_green,
    input logic [15:0]        s_sdr_blue,
    input logic [15:0]        s_gain_red,
    input logic [15:0]        s_gain_green,
    input logic [15:0]        s_gain_blue,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [24:0] m_hdr_red,
    input logic signed [24:0] m_hdr_green,
    input logic signed [24:0] m_hdr_blue,
    input logic               m_clipped
);

    logic on_rail;

    assign on_rail = (m_hdr_red == OUT_MAX) || (m_hdr_red == OUT_MIN) ||
                     (m_hdr_green == OUT_MAX) || (m_hdr_green == OUT_MIN) ||
                     (m_hdr_blue == OUT_MAX) || (m_hdr_blue == OUT_MIN);

    // reset empties the pipe
    `HGM_ASSERT_RST(a_reset_empty, aclk, !aresetn, !m_valid)

    // an empty or draining output stage lets the input stage take a word
    `HGM_ASSERT_IMP(a_drain_ready, aclk, aresetn, !m_valid || m_ready, s_ready)

    // the clip flag only comes with a channel on a rail
    `HGM_ASSERT_IMP(a_clip_rail, aclk, aresetn, m_valid && m_clipped, on_rail)

    // hold a stalled result word
    `HGM_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_hdr_red) && $stable(m_hdr_green) && $stable(m_hdr_blue) && $stable(m_clipped))

endmodule

bind hdr_gain_map_apply hgm_checker u_chk (.*);
